### rtl/stbp_pkg.sv
// shared types, constants and command codes of the serial transmit buffer port
// depends on nothing; every module of the block imports it
package stbp_pkg;

   localparam int DEPTH  = 128;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;
   localparam int BUDGET_W = 6;
   localparam int REQ_TDATA_W = 40;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 40;
   localparam int QCNT_W = 2;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_TICK  = 2'd2
   } cmd_type;

   localparam logic REG_DATA = 1'b0;
   localparam logic REG_CMD  = 1'b1;

   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_TX   = 1'b1;

   localparam logic [DATA_W-1:0] IRQ_ON        = 32'h0000_0004;
   localparam logic [DATA_W-1:0] IRQ_OFF       = 32'h0000_0005;
   localparam logic [DATA_W-1:0] DATA_READBACK = 32'hFFFF_FFFF;

   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic              rd_en;
      logic [IDX_W-1:0]  rd_addr;
   } store_req_type;

   typedef struct packed {
      logic              kind;
      logic [DATA_W-1:0] value;
      logic              irq;
      logic              last;
   } rsp_item_type;

   typedef struct packed {
      logic             busy;
      logic [CNT_W-1:0] fill;
   } stat_type;

endpackage

### rtl/stbp_store.sv
// transmit word store: one write port, one read port with registered data
// depends on stbp_pkg
module stbp_store (
   input  logic                  clock,
   input  stbp_pkg::store_req_type req,
   output logic [stbp_pkg::DATA_W-1:0] rd_data
);
   import stbp_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff <= mem[req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/stbp_rspq.sv
// two-word result queue between the sequencer and the result channel
// depends on stbp_pkg
module stbp_rspq (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  stbp_pkg::rsp_item_type       push_item,
   output logic                         out_valid,
   input  logic                         out_ready,
   output stbp_pkg::rsp_item_type       out_item,
   output logic                         pop,
   output logic [stbp_pkg::QCNT_W-1:0]  count
);
   import stbp_pkg::*;

   rsp_item_type      ent_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      pop       = (count_ff != '0) && out_ready;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_item  = ent_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

### rtl/stbp_ctrl.sv
// sequencer: register decode, fill and send indices, drain of the store
// depends on stbp_pkg; drives stbp_store and feeds stbp_rspq
module stbp_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_cmd,
   input  logic                            req_reg_sel,
   input  logic [stbp_pkg::DATA_W-1:0]     req_write_value,
   input  logic [stbp_pkg::BUDGET_W-1:0]   req_tick_budget,
   output stbp_pkg::store_req_type         store_req,
   input  logic [stbp_pkg::DATA_W-1:0]     store_rd_data,
   input  logic [stbp_pkg::QCNT_W-1:0]     q_count,
   input  logic                            q_pop,
   output logic                            q_push,
   output stbp_pkg::rsp_item_type          q_item,
   output stbp_pkg::stat_type              stat
);
   import stbp_pkg::*;

   typedef enum logic {ST_IDLE, ST_DRAIN} state_type;

   typedef struct packed {
      logic         valid;
      logic         from_mem;
      rsp_item_type item;
   } meta_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic [IDX_W-1:0]    send_ff, send_in;
   logic                busy_ff, busy_in;
   logic                irq_en_ff, irq_en_in;
   logic [BUDGET_W-1:0] budget_ff, budget_in;
   meta_type            meta_ff, meta_in;

   logic             slot_ok;
   logic             accept;
   logic [CNT_W-1:0] next_send;
   logic             empty;
   logic             last_word;
   cmd_type          cmd;

   always_comb begin
      cmd = cmd_type'(req_cmd);
      // room in the queue counting the word still in flight from the store
      slot_ok = ({1'b0, q_count} + {2'b0, meta_ff.valid}) < (3'd2 + {2'b0, q_pop});
      req_ready = (state_ff == ST_IDLE) && slot_ok;
      accept    = req_valid && req_ready;

      next_send = {{(CNT_W-IDX_W){1'b0}}, send_ff} + CNT_W'(1);
      empty     = (next_send == fill_ff);
      last_word = empty || (budget_ff == BUDGET_W'(1));

      state_in  = state_ff;
      fill_in   = fill_ff;
      send_in   = send_ff;
      busy_in   = busy_ff;
      irq_en_in = irq_en_ff;
      budget_in = budget_ff;
      meta_in   = meta_ff;
      meta_in.valid = 1'b0;

      store_req.wr_en   = 1'b0;
      store_req.wr_addr = fill_ff[IDX_W-1:0];
      store_req.wr_data = req_write_value;
      store_req.rd_en   = 1'b0;
      store_req.rd_addr = send_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (cmd)
                  CMD_WRITE: begin
                     if (req_reg_sel == REG_DATA) begin
                        if (fill_ff < CNT_W'(DEPTH)) begin
                           store_req.wr_en = 1'b1;
                           fill_in = fill_ff + CNT_W'(1);
                           if (fill_in == CNT_W'(DEPTH)) begin
                              busy_in = 1'b1;
                           end
                        end
                     end else if (req_write_value == IRQ_ON) begin
                        irq_en_in = 1'b1;
                     end else if (req_write_value == IRQ_OFF) begin
                        irq_en_in = 1'b0;
                     end
                  end
                  CMD_READ: begin
                     meta_in.valid      = 1'b1;
                     meta_in.from_mem   = 1'b0;
                     meta_in.item.kind  = KIND_READ;
                     meta_in.item.value = (req_reg_sel == REG_CMD) ?
                                          {{(DATA_W-1){1'b0}}, busy_ff} : DATA_READBACK;
                     meta_in.item.irq   = 1'b0;
                     meta_in.item.last  = 1'b1;
                  end
                  CMD_TICK: begin
                     if ((req_tick_budget != '0) && (fill_ff != '0)) begin
                        budget_in = req_tick_budget;
                        state_in  = ST_DRAIN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DRAIN: begin
            if (slot_ok) begin
               store_req.rd_en    = 1'b1;
               meta_in.valid      = 1'b1;
               meta_in.from_mem   = 1'b1;
               meta_in.item.kind  = KIND_TX;
               meta_in.item.value = '0;
               meta_in.item.irq   = empty && irq_en_ff;
               meta_in.item.last  = last_word;
               budget_in = budget_ff - BUDGET_W'(1);
               if (empty) begin
                  fill_in = '0;
                  send_in = '0;
                  busy_in = 1'b0;
               end else begin
                  send_in = next_send[IDX_W-1:0];
               end
               if (last_word) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      q_push = meta_ff.valid;
      q_item = meta_ff.item;
      if (meta_ff.from_mem) begin
         q_item.value = store_rd_data;
      end

      stat.busy = busy_ff;
      stat.fill = fill_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fill_ff   <= '0;
         send_ff   <= '0;
         busy_ff   <= 1'b0;
         irq_en_ff <= 1'b0;
         budget_ff <= '0;
         meta_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         send_ff   <= send_in;
         busy_ff   <= busy_in;
         irq_en_ff <= irq_en_in;
         budget_ff <= budget_in;
         meta_ff   <= meta_in;
      end
   end

endmodule

### rtl/serial_tx_buffer_port_top.sv
// serial transmit buffer port: bus writes fill a word store, ticks drain it
// a bus read word passes through the sequencer's result register into the result queue; a tick
// enters the drain state, then sends one word per cycle from the single store read port while
// the result queue has room; no request is taken while a tick drains the store
// reset: synchronous, clears indices, busy, interrupt enable and the result queue;
// the store itself is not cleared, only written entries are ever read
module serial_tx_buffer_port_top (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [stbp_pkg::REQ_TDATA_W-1:0]    req_tdata,  // write_value, tick_budget, zero pad
   input  logic [stbp_pkg::REQ_TUSER_W-1:0]    req_tuser,  // cmd, reg_sel
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [stbp_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // value, irq, zero pad
   output logic [0:0]                          rsp_tuser,  // kind
   output logic                                rsp_tlast
);
   import stbp_pkg::*;

   store_req_type     store_req;
   logic [DATA_W-1:0] store_rd_data;
   logic [QCNT_W-1:0] q_count;
   logic              q_pop;
   logic              q_push;
   rsp_item_type      q_item;
   rsp_item_type      out_item;
   stat_type          stat;

   // sequencer owns the store indices and all flags; store holds the words
   stbp_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_tvalid),
      .req_ready       (req_tready),
      .req_cmd         (req_tuser[1:0]),
      .req_reg_sel     (req_tuser[2]),
      .req_write_value (req_tdata[31:0]),
      .req_tick_budget (req_tdata[37:32]),
      .store_req       (store_req),
      .store_rd_data   (store_rd_data),
      .q_count         (q_count),
      .q_pop           (q_pop),
      .q_push          (q_push),
      .q_item          (q_item),
      .stat            (stat)
   );

   stbp_store u_store (
      .clock   (clock),
      .req     (store_req),
      .rd_data (store_rd_data)
   );

   // result queue decouples the drain from a stalled consumer
   stbp_rspq u_rspq (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item),
      .pop       (q_pop),
      .count     (q_count)
   );

   // pack result word
   assign rsp_tdata = {{(RSP_TDATA_W-DATA_W-1){1'b0}}, out_item.irq, out_item.value};
   assign rsp_tuser = out_item.kind;
   assign rsp_tlast = out_item.last;

   // queue comes out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // credit check in the sequencer must keep the queue from overflowing
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (q_push && (q_count == QCNT_W'(2))) |-> q_pop)
      else $error("result queue overflow");

   // busy tracks a full store
   a_busy_full: assert property (@(posedge clock) disable iff (reset)
      stat.busy == (stat.fill == CNT_W'(DEPTH)))
      else $error("busy flag out of step with fill index");

endmodule

### sim/stbp_word_check.sv
// result predictor and comparator for the serial transmit buffer port
// watches the request and result channels of the block; depends on stbp_pkg
module stbp_word_check
   import stbp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // write_value, tick_budget, zero pad
   input  logic [REQ_TUSER_W-1:0] req_tuser,   // cmd, reg_sel
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,   // value, irq, zero pad
   input  logic [0:0]             rsp_tuser,   // kind
   input  logic                   rsp_tlast,
   output int                     mismatch_count,
   output int                     pending_words
);

   // shadow of the port state
   logic [DATA_W-1:0] tx_words [DEPTH];
   int unsigned       words_held;
   int unsigned       words_sent;
   logic              store_full;
   logic              irq_armed;

   rsp_item_type      predicted_words[$];

   initial mismatch_count = 0;

   task automatic predict_request(input logic [1:0] cmd, input logic sel,
                                  input logic [DATA_W-1:0] wval,
                                  input logic [BUDGET_W-1:0] budget);
      rsp_item_type word;
      int unsigned  budget_left;
      budget_left = budget;
      case (cmd)
         CMD_WRITE: begin
            if (sel == REG_DATA) begin
               // dropped once the store is full
               if (words_held < DEPTH) begin
                  tx_words[IDX_W'(words_held)] = wval;
                  words_held++;
                  if (words_held == DEPTH) store_full = 1'b1;
               end
            end else if (wval == IRQ_ON) begin
               irq_armed = 1'b1;
            end else if (wval == IRQ_OFF) begin
               irq_armed = 1'b0;
            end
         end
         CMD_READ: begin
            word.kind  = KIND_READ;
            word.value = (sel == REG_CMD) ? {{(DATA_W-1){1'b0}}, store_full} : DATA_READBACK;
            word.irq   = 1'b0;
            word.last  = 1'b1;
            predicted_words.push_back(word);
         end
         CMD_TICK: begin
            while (budget_left > 0 && words_sent < words_held) begin
               word.kind  = KIND_TX;
               word.value = tx_words[IDX_W'(words_sent)];
               word.irq   = 1'b0;
               words_sent++;
               // store drained: indices and busy return to zero
               if (words_sent == words_held) begin
                  words_sent = 0;
                  words_held = 0;
                  store_full = 1'b0;
                  word.irq   = irq_armed;
               end
               word.last = (budget_left == 1) || (words_sent == words_held);
               predicted_words.push_back(word);
               budget_left--;
            end
         end
         default: ;
      endcase
   endtask

   task automatic compare_word(input rsp_item_type got);
      rsp_item_type want;
      if (predicted_words.size() == 0) begin
         $error("result word with nothing predicted: kind %0d value %h",
                got.kind, got.value);
         mismatch_count++;
      end else begin
         want = predicted_words.pop_front();
         if (got.kind !== want.kind) begin
            $error("kind: expected %0d actual %0d", want.kind, got.kind);
            mismatch_count++;
         end
         if (got.value !== want.value) begin
            $error("value: expected %h actual %h", want.value, got.value);
            mismatch_count++;
         end
         if (got.irq !== want.irq) begin
            $error("irq: expected %0d actual %0d", want.irq, got.irq);
            mismatch_count++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d actual %0d", want.last, got.last);
            mismatch_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         words_held = 0;
         words_sent = 0;
         store_full = 1'b0;
         irq_armed  = 1'b0;
         predicted_words.delete();
      end else begin
         // a result never leaves in the same cycle as its request, so compare before predict
         if (rsp_tvalid && rsp_tready)
            compare_word({rsp_tuser[0], rsp_tdata[DATA_W-1:0], rsp_tdata[DATA_W], rsp_tlast});
         if (req_tvalid && req_tready)
            predict_request(req_tuser[1:0], req_tuser[2], req_tdata[DATA_W-1:0],
                            req_tdata[DATA_W+BUDGET_W-1:DATA_W]);
      end
      pending_words <= predicted_words.size();
   end

endmodule

### sim/serial_tx_buffer_port_top_tb.sv
// testbench top for the serial transmit buffer port: clock, reset, stimulus and verdict
// depends on stbp_pkg, serial_tx_buffer_port_top and stbp_word_check
module serial_tx_buffer_port_top_tb;
   import stbp_pkg::*;

   localparam logic [1:0] CMD_UNUSED  = 2'd3;   // reserved command, block ignores it
   localparam int         HOLD_CYCLES = 300;    // long receiver hold-off
   localparam int         STALL_LIMIT = 2000;   // cycles with no word moving
   localparam int         DRAIN_WAIT  = 8;      // settle time after the last result

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;      // write_value, tick_budget, zero pad
   logic [REQ_TUSER_W-1:0] req_tuser = '0;      // cmd, reg_sel
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;           // value, irq, zero pad
   logic [0:0]             rsp_tuser;           // kind
   logic                   rsp_tlast;

   int   mismatch_count;
   int   pending_words;
   int   stall_cycles = 0;
   bit   quiet = 1'b0;             // set for the tail of the run: no idling
   bit   hold_off_request = 1'b0;  // asks the receiver for one long stall

   always #5 clock = ~clock;

   serial_tx_buffer_port_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   stbp_word_check word_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .pending_words  (pending_words)
   );

   // one request word; an optional idle burst goes in front of it
   task automatic send_request(input logic [1:0] cmd, input logic sel,
                               input logic [DATA_W-1:0] wval,
                               input logic [BUDGET_W-1:0] budget);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, budget, wval};
      req_tuser  <= {sel, cmd};
      // hold the word until the block takes it
      do @(posedge clock); while (!req_tready);
   endtask

   // random bus traffic with random don't-care fields
   task automatic send_mixed_traffic(input int count);
      int                  pick;
      logic [DATA_W-1:0]   wval;
      logic [BUDGET_W-1:0] budget;
      for (int i = 0; i < count; i++) begin
         pick   = $urandom_range(0, 99);
         wval   = $urandom();
         // mostly short ticks so the store keeps some words, sometimes the full range
         budget = BUDGET_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                        : $urandom_range(0, 6));
         if (pick < 45)
            send_request(CMD_WRITE, REG_DATA, wval, budget);
         else if (pick < 55)
            send_request(CMD_WRITE, REG_CMD,
                         (pick < 50) ? ((pick & 1) ? IRQ_ON : IRQ_OFF) : wval, budget);
         else if (pick < 70)
            send_request(CMD_READ, 1'($urandom_range(0, 1)), wval, budget);
         else if (pick < 95)
            send_request(CMD_TICK, 1'($urandom_range(0, 1)), wval, budget);
         else
            send_request(CMD_UNUSED, 1'($urandom_range(0, 1)), wval, budget);
      end
   endtask

   // fill the store to the top, push past it, then drain under a long result stall
   task automatic fill_and_drain();
      for (int i = 0; i < DEPTH + 2; i++)
         send_request(CMD_WRITE, REG_DATA, $urandom(), BUDGET_W'($urandom_range(0, 63)));
      send_request(CMD_READ, REG_CMD, $urandom(), BUDGET_W'($urandom_range(0, 63)));
      send_request(CMD_WRITE, REG_CMD, $urandom_range(0, 1) ? IRQ_ON : IRQ_OFF, 6'd0);
      hold_off_request = 1'b1;
      send_request(CMD_TICK, REG_DATA, $urandom(), 6'd63);
      // still full until the last word leaves, so this one is dropped
      send_request(CMD_WRITE, REG_DATA, $urandom(), 6'd0);
      send_request(CMD_READ, REG_CMD, 32'd0, 6'd0);
      send_request(CMD_TICK, REG_CMD, $urandom(), 6'd63);
      send_request(CMD_TICK, REG_DATA, $urandom(), 6'd63);
      send_request(CMD_READ, REG_CMD, 32'd0, 6'd0);
   endtask

   // stimulus and verdict
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: readbacks on an empty port
      send_request(CMD_READ, REG_DATA, 32'd0, 6'd0);
      send_request(CMD_READ, REG_CMD, 32'hFFFF_FFFF, 6'd63);
      send_request(CMD_TICK, REG_DATA, 32'd0, 6'd5);            // nothing to send
      // interrupt on, three words, zero-budget tick, then a partial and a full drain
      send_request(CMD_WRITE, REG_CMD, IRQ_ON, 6'd0);
      send_request(CMD_WRITE, REG_DATA, 32'h0000_0000, 6'd63);
      send_request(CMD_WRITE, REG_DATA, 32'hFFFF_FFFF, 6'd0);
      send_request(CMD_WRITE, REG_DATA, 32'hA5A5_A5A5, 6'd21);
      send_request(CMD_TICK, REG_DATA, 32'hFFFF_FFFF, 6'd0);
      send_request(CMD_TICK, REG_CMD, 32'd0, 6'd1);
      send_request(CMD_TICK, REG_DATA, 32'd0, 6'd63);            // drain with irq
      // interrupt off, drain without irq
      send_request(CMD_WRITE, REG_CMD, IRQ_OFF, 6'd0);
      send_request(CMD_WRITE, REG_DATA, 32'h1234_5678, 6'd0);
      send_request(CMD_TICK, REG_DATA, 32'd0, 6'd63);
      // command writes other than on/off, and the reserved command
      send_request(CMD_WRITE, REG_CMD, 32'hFFFF_FFFF, 6'd0);
      send_request(CMD_WRITE, REG_CMD, 32'h0000_0006, 6'd0);
      send_request(CMD_WRITE, REG_CMD, 32'h0000_0104, 6'd0);
      send_request(CMD_UNUSED, REG_CMD, IRQ_ON, 6'd63);
      send_request(CMD_UNUSED, REG_DATA, 32'h5A5A_5A5A, 6'd1);
      // irq must still be off here, then on again with single-word ticks
      send_request(CMD_WRITE, REG_DATA, 32'h8000_0001, 6'd0);
      send_request(CMD_TICK, REG_DATA, 32'd0, 6'd1);
      send_request(CMD_WRITE, REG_CMD, IRQ_ON, 6'd0);
      send_request(CMD_WRITE, REG_DATA, 32'h7FFF_FFFE, 6'd0);
      send_request(CMD_WRITE, REG_DATA, 32'h0F0F_F0F0, 6'd0);
      send_request(CMD_READ, REG_CMD, 32'd0, 6'd0);
      send_request(CMD_TICK, REG_DATA, 32'd0, 6'd1);
      send_request(CMD_TICK, REG_CMD, 32'd0, 6'd1);

      // random part
      send_mixed_traffic(5);
      fill_and_drain();
      send_mixed_traffic(3);
      quiet = 1'b1;
      send_mixed_traffic(5);
      req_tvalid <= 1'b0;

      // wait for every predicted word, then let the pipe settle
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0)
         $display("serial_tx_buffer_port_top verification clean");
      else
         $display("serial_tx_buffer_port_top verification failed");
      $finish;
   end

   // result receiver: random stalls, one long hold-off on request, none at the tail
   initial begin
      forever begin
         if (hold_off_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_request = 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // watchdog: too long without a word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("serial_tx_buffer_port_top verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule

### sim.f
rtl/stbp_pkg.sv
rtl/stbp_store.sv
rtl/stbp_rspq.sv
rtl/stbp_ctrl.sv
rtl/serial_tx_buffer_port_top.sv
sim/stbp_word_check.sv
sim/serial_tx_buffer_port_top_tb.sv
